// ===== hw/rtl/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// IR pulse-distance decoder package
// Shared widths, register indexes, configuration and result types.
// ----------------------------------------------------------------------------
package irpd_pkg;

   localparam int TimeW      = 14;
   localparam int CodeW      = 32;
   localparam int ByteW      = 8;
   localparam int CodeIdxW   = 5;
   localparam int CsrIndexW  = 3;
   localparam int FrameBitsDefault = 32;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_MIN_LEADER_TIME       = 3'd0,
      CSR_MAX_LEADER_PULSE      = 3'd1,
      CSR_MIN_FULL_LEADER_SPACE = 3'd2,
      CSR_MAX_LEADER_SPACE      = 3'd3,
      CSR_MIN_BIT_TIME          = 3'd4,
      CSR_ZERO_ONE_SPLIT        = 3'd5,
      CSR_MAX_BIT_TIME          = 3'd6,
      CSR_GAP_TIMEOUT           = 3'd7
   } csr_index_type;

   localparam logic [TimeW-1:0] RstMinLeaderTime      = 14'd2000;
   localparam logic [TimeW-1:0] RstMaxLeaderPulse     = 14'd9500;
   localparam logic [TimeW-1:0] RstMinFullLeaderSpace = 14'd4000;
   localparam logic [TimeW-1:0] RstMaxLeaderSpace     = 14'd5000;
   localparam logic [TimeW-1:0] RstMinBitTime         = 14'd400;
   localparam logic [TimeW-1:0] RstZeroOneSplit       = 14'd1000;
   localparam logic [TimeW-1:0] RstMaxBitTime         = 14'd2000;
   localparam logic [TimeW-1:0] RstGapTimeout         = 14'd10000;

   localparam logic [ByteW-1:0] ByteInvalid = 8'hFF;

   typedef struct packed {
      logic [TimeW-1:0] min_leader_time;
      logic [TimeW-1:0] max_leader_pulse;
      logic [TimeW-1:0] min_full_leader_space;
      logic [TimeW-1:0] max_leader_space;
      logic [TimeW-1:0] min_bit_time;
      logic [TimeW-1:0] zero_one_split;
      logic [TimeW-1:0] max_bit_time;
      logic [TimeW-1:0] gap_timeout;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [CodeW-1:0] raw_code;
      logic [ByteW-1:0] address_byte;
      logic [ByteW-1:0] command_byte;
      logic             is_repeat;
   } result_type;

endpackage

// ===== hw/rtl/irpd_csr.sv =====
// ----------------------------------------------------------------------------
// IR decoder configuration registers
// Holds the eight timing windows, written through a plain write port.
// ----------------------------------------------------------------------------
module irpd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [irpd_pkg::CsrIndexW-1:0] csr_index,
   input  logic [irpd_pkg::TimeW-1:0]    csr_write_data,
   output irpd_pkg::cfg_type             cfg
);
   import irpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_LEADER_TIME:       cfg_in.min_leader_time       = csr_write_data;
            CSR_MAX_LEADER_PULSE:      cfg_in.max_leader_pulse      = csr_write_data;
            CSR_MIN_FULL_LEADER_SPACE: cfg_in.min_full_leader_space = csr_write_data;
            CSR_MAX_LEADER_SPACE:      cfg_in.max_leader_space      = csr_write_data;
            CSR_MIN_BIT_TIME:          cfg_in.min_bit_time          = csr_write_data;
            CSR_ZERO_ONE_SPLIT:        cfg_in.zero_one_split        = csr_write_data;
            CSR_MAX_BIT_TIME:          cfg_in.max_bit_time          = csr_write_data;
            CSR_GAP_TIMEOUT:           cfg_in.gap_timeout           = csr_write_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_leader_time       <= RstMinLeaderTime;
         cfg_ff.max_leader_pulse      <= RstMaxLeaderPulse;
         cfg_ff.min_full_leader_space <= RstMinFullLeaderSpace;
         cfg_ff.max_leader_space      <= RstMaxLeaderSpace;
         cfg_ff.min_bit_time          <= RstMinBitTime;
         cfg_ff.zero_one_split        <= RstZeroOneSplit;
         cfg_ff.max_bit_time          <= RstMaxBitTime;
         cfg_ff.gap_timeout           <= RstGapTimeout;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/irpd_core.sv =====
// ----------------------------------------------------------------------------
// IR decoder frame state machine
// Walks leader pulse, leader space and data bits for one edge per cycle in which fire is high.
// ----------------------------------------------------------------------------
module irpd_core #(
   parameter int FRAME_BITS = irpd_pkg::FrameBitsDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [irpd_pkg::TimeW-1:0] interval_us,
   input  logic                       pin_level,
   input  irpd_pkg::cfg_type          cfg,
   output irpd_pkg::result_type       result
);
   import irpd_pkg::*;

   localparam int CntW = $clog2(FRAME_BITS + 1);

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_LPULSE = 2'd1,
      PH_LSPACE = 2'd2,
      PH_DATA   = 2'd3
   } phase_type;

   phase_type        phase_ff, phase_in, phase_eff;
   logic [CntW-1:0]  bit_count_ff, bit_count_in, bit_count_inc;
   logic [CodeW-1:0] code_shift_ff, code_shift_in;
   logic             emit;
   logic             emit_repeat;
   logic [CodeW-1:0] emit_code;

   always_comb begin
      phase_eff = phase_ff;
      if (phase_ff != PH_IDLE && interval_us >= cfg.gap_timeout) begin
         phase_eff = PH_IDLE;
      end
      bit_count_inc = bit_count_ff + CntW'(1);
   end

   always_comb begin
      phase_in      = phase_eff;
      bit_count_in  = bit_count_ff;
      code_shift_in = code_shift_ff;
      emit          = 1'b0;
      emit_repeat   = 1'b0;
      emit_code     = code_shift_ff;
      case (phase_eff)
         PH_IDLE: begin
            phase_in = PH_LPULSE;
         end
         PH_LPULSE: begin
            if (interval_us < cfg.min_leader_time || interval_us > cfg.max_leader_pulse) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_LSPACE;
            end
         end
         PH_LSPACE: begin
            if (interval_us < cfg.min_leader_time || interval_us > cfg.max_leader_space) begin
               phase_in = PH_IDLE;
            end else if (interval_us < cfg.min_full_leader_space) begin
               phase_in    = PH_IDLE;
               emit        = 1'b1;
               emit_repeat = 1'b1;
            end else begin
               phase_in      = PH_DATA;
               bit_count_in  = '0;
               code_shift_in = '0;
            end
         end
         PH_DATA: begin
            if (!pin_level) begin
               if (interval_us > cfg.max_bit_time || interval_us < cfg.min_bit_time) begin
                  phase_in = PH_IDLE;
               end else begin
                  if (interval_us >= cfg.zero_one_split) begin
                     code_shift_in[CodeIdxW'(bit_count_ff)] = 1'b1;
                  end
                  bit_count_in = bit_count_inc;
                  emit_code    = code_shift_in;
                  if (bit_count_inc == CntW'(FRAME_BITS)) begin
                     phase_in = PH_IDLE;
                     emit     = 1'b1;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         code_shift_ff <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         code_shift_ff <= code_shift_in;
      end
   end

   always_comb begin
      result.valid     = fire && emit;
      result.raw_code  = emit_code;
      result.is_repeat = emit_repeat;
      if (emit_code[7:0] == ~emit_code[15:8]) begin
         result.address_byte = emit_code[7:0];
      end else begin
         result.address_byte = ByteInvalid;
      end
      if (emit_code[23:16] == ~emit_code[31:24]) begin
         result.command_byte = emit_code[23:16];
      end else begin
         result.command_byte = ByteInvalid;
      end
   end

endmodule

// ===== hw/rtl/ir_remote_pulse_distance_decoder.sv =====
// Accepted words enter the input register; frame ends then load the result register.
// Throughput: one receiver edge per cycle unless a waiting result word stalls input.
// The input register holds a word only while the result register waits to be taken.
// Reset clears the frame state and both valid flags and loads the default timing windows.
// ----------------------------------------------------------------------------
// IR remote pulse-distance decoder
// Decodes NEC-style frames from receiver edge intervals into code, address and command.
// ----------------------------------------------------------------------------
module ir_remote_pulse_distance_decoder #(
   parameter int FRAME_BITS = irpd_pkg::FrameBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [irpd_pkg::TimeW-1:0]     req_interval_us,
   input  logic                           req_pin_level,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [irpd_pkg::CodeW-1:0]     rsp_raw_code,
   output logic [irpd_pkg::ByteW-1:0]     rsp_address_byte,
   output logic [irpd_pkg::ByteW-1:0]     rsp_command_byte,
   output logic                           rsp_is_repeat,
   input  logic                           csr_write_enable,
   input  logic [irpd_pkg::CsrIndexW-1:0] csr_index,
   input  logic [irpd_pkg::TimeW-1:0]     csr_write_data
);
   import irpd_pkg::*;

   cfg_type          cfg;
   result_type       result;
   logic             req_valid_ff, req_valid_in;
   logic [TimeW-1:0] interval_ff;
   logic             pin_level_ff;
   logic             advance;
   logic             fire;
   result_type       rsp_ff;
   logic             rsp_valid_in;

   irpd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   irpd_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .interval_us (interval_ff),
      .pin_level   (pin_level_ff),
      .cfg         (cfg),
      .result      (result)
   );

   assign advance   = !rsp_ff.valid || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
      end
      rsp_valid_in = rsp_ff.valid;
      if (fire && result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_ff.valid <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_ff.valid <= rsp_valid_in;
      end
      if (!req_stall) begin
         interval_ff  <= req_interval_us;
         pin_level_ff <= req_pin_level;
      end
      if (fire && result.valid) begin
         rsp_ff.raw_code     <= result.raw_code;
         rsp_ff.address_byte <= result.address_byte;
         rsp_ff.command_byte <= result.command_byte;
         rsp_ff.is_repeat    <= result.is_repeat;
      end
   end

   assign rsp_valid        = rsp_ff.valid;
   assign rsp_raw_code     = rsp_ff.raw_code;
   assign rsp_address_byte = rsp_ff.address_byte;
   assign rsp_command_byte = rsp_ff.command_byte;
   assign rsp_is_repeat    = rsp_ff.is_repeat;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IR remote pulse-distance decoder testbench
// Drives receiver edge words through frames, repeats, broken frames and noise
// under several timing windows, predicts every decoded code in step with the
// block, and checks each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import irpd_pkg::*;

   localparam int FrameBits = FrameBitsDefault;
   localparam int MaxTime = (1 << TimeW) - 1;
   localparam int NoCut = 1000;
   localparam int HoldCycles = 300;
   localparam int IdleTail = 4;
   localparam int ItemBudget = 1550;
   localparam cfg_type ResetWindows = '{RstMinLeaderTime, RstMaxLeaderPulse,
      RstMinFullLeaderSpace, RstMaxLeaderSpace, RstMinBitTime, RstZeroOneSplit,
      RstMaxBitTime, RstGapTimeout};

   typedef enum logic [1:0] {PH_IDLE, PH_LEAD_PULSE, PH_LEAD_SPACE, PH_DATA} phase_type;
   typedef enum {FRAME_FULL, FRAME_REPEAT} frame_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [TimeW-1:0] req_interval_us = '0;
   logic req_pin_level = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CodeW-1:0] rsp_raw_code;
   logic [ByteW-1:0] rsp_address_byte;
   logic [ByteW-1:0] rsp_command_byte;
   logic rsp_is_repeat;
   logic csr_write_enable = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [TimeW-1:0] csr_write_data = '0;

   cfg_type win;
   phase_type ph;
   logic [5:0] bits_taken;
   logic [CodeW-1:0] code_acc;
   result_type code_q[$];

   int errors = 0;
   int edges_sent = 0;
   int idle_pct = 25;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;

   ir_remote_pulse_distance_decoder #(.FRAME_BITS(FrameBits)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_interval_us  (req_interval_us),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_raw_code     (rsp_raw_code),
      .rsp_address_byte (rsp_address_byte),
      .rsp_command_byte (rsp_command_byte),
      .rsp_is_repeat    (rsp_is_repeat),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic result_type frame_report(input logic [CodeW-1:0] code,
                                               input logic rep);
      result_type r;
      r.valid = 1'b1;
      r.raw_code = code;
      r.address_byte = (code[7:0] == ~code[15:8]) ? code[7:0] : ByteInvalid;
      r.command_byte = (code[23:16] == ~code[31:24]) ? code[23:16] : ByteInvalid;
      r.is_repeat = rep;
      return r;
   endfunction

   function automatic bit decode_edge(input logic [TimeW-1:0] t, input logic pin,
                                      output result_type r);
      r = '0;
      if (ph != PH_IDLE && t >= win.gap_timeout) begin
         ph = PH_IDLE;
      end
      case (ph)
         PH_IDLE: begin
            ph = PH_LEAD_PULSE;
         end
         PH_LEAD_PULSE: begin
            if (t < win.min_leader_time || t > win.max_leader_pulse) begin
               ph = PH_IDLE;
            end else begin
               ph = PH_LEAD_SPACE;
            end
         end
         PH_LEAD_SPACE: begin
            if (t < win.min_leader_time || t > win.max_leader_space) begin
               ph = PH_IDLE;
            end else if (t < win.min_full_leader_space) begin
               ph = PH_IDLE;
               r = frame_report(code_acc, 1'b1);
               return 1'b1;
            end else begin
               ph = PH_DATA;
               bits_taken = '0;
               code_acc = '0;
            end
         end
         default: begin
            if (!pin) begin
               if (t > win.max_bit_time || t < win.min_bit_time) begin
                  ph = PH_IDLE;
               end else begin
                  if (t >= win.zero_one_split && bits_taken < 6'd32) begin
                     code_acc[bits_taken[4:0]] = 1'b1;
                  end
                  bits_taken = bits_taken + 6'd1;
                  if (bits_taken >= FrameBits) begin
                     ph = PH_IDLE;
                     r = frame_report(code_acc, 1'b0);
                     return 1'b1;
                  end
               end
            end
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void note_mismatch(input string what, input result_type want,
                                         input result_type got);
      errors++;
      if (errors <= 10) begin
         $display("%0t: %s: expected %h/%h/%h/%b, got %h/%h/%h/%b", $time, what,
                  want.raw_code, want.address_byte, want.command_byte, want.is_repeat,
                  got.raw_code, got.address_byte, got.command_byte, got.is_repeat);
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         win = ResetWindows;
         ph = PH_IDLE;
         bits_taken = '0;
         code_acc = '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_MIN_LEADER_TIME:       win.min_leader_time = csr_write_data;
               CSR_MAX_LEADER_PULSE:      win.max_leader_pulse = csr_write_data;
               CSR_MIN_FULL_LEADER_SPACE: win.min_full_leader_space = csr_write_data;
               CSR_MAX_LEADER_SPACE:      win.max_leader_space = csr_write_data;
               CSR_MIN_BIT_TIME:          win.min_bit_time = csr_write_data;
               CSR_ZERO_ONE_SPLIT:        win.zero_one_split = csr_write_data;
               CSR_MAX_BIT_TIME:          win.max_bit_time = csr_write_data;
               default:                   win.gap_timeout = csr_write_data;
            endcase
         end
         if (req_valid && !req_stall && decode_edge(req_interval_us, req_pin_level, want)) begin
            code_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{1'b1, rsp_raw_code, rsp_address_byte, rsp_command_byte, rsp_is_repeat};
            if (code_q.size() == 0) begin
               note_mismatch("word with nothing expected", '0, got);
            end else begin
               want = code_q.pop_front();
               if (got !== want) begin
                  note_mismatch("code mismatch", want, got);
               end
            end
         end
      end
   end

   // The receiver takes a long hold-off whenever one is asked for, else stalls at random.
   always @(negedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served = holds_asked;
         hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < idle_pct);
      end
   end

   function automatic int pick(input int lo, input int hi);
      return (lo > hi) ? lo : int'($urandom_range(hi, lo));
   endfunction

   function automatic int lesser(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int larger(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic cfg_type make_windows(input int lmin, input int pmax, input int fmin,
                                            input int smax, input int bmin, input int split,
                                            input int bmax, input int gap);
      cfg_type w;
      w.min_leader_time = TimeW'(lmin);
      w.max_leader_pulse = TimeW'(pmax);
      w.min_full_leader_space = TimeW'(fmin);
      w.max_leader_space = TimeW'(smax);
      w.min_bit_time = TimeW'(bmin);
      w.zero_one_split = TimeW'(split);
      w.max_bit_time = TimeW'(bmax);
      w.gap_timeout = TimeW'(gap);
      return w;
   endfunction

   function automatic cfg_type nominal_windows();
      int lmin;
      int pmax;
      int fmin;
      int smax;
      int bmin;
      int split;
      int bmax;
      lmin = $urandom_range(3000, 1000);
      pmax = lmin + $urandom_range(9000, 2000);
      fmin = lmin + $urandom_range(3000, 500);
      smax = fmin + $urandom_range(2000, 200);
      bmin = $urandom_range(600, 100);
      split = bmin + $urandom_range(1500, 100);
      bmax = split + $urandom_range(2000, 100);
      return make_windows(lmin, pmax, fmin, smax, bmin, split, bmax,
                          pick(larger(pmax, larger(smax, bmax)) + 1, MaxTime));
   endfunction

   function automatic logic [CodeW-1:0] random_code();
      logic [7:0] a;
      logic [7:0] c;
      logic [CodeW-1:0] code;
      a = 8'($urandom);
      c = 8'($urandom);
      code = {~c, c, ~a, a};
      if ($urandom_range(0, 99) < 30) begin
         code[$urandom_range(0, 31)] ^= 1'b1;
      end else if ($urandom_range(0, 99) < 30) begin
         code = $urandom;
      end
      return code;
   endfunction

   task automatic send_edge(input int t, input logic pin);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_interval_us <= t[TimeW-1:0];
      req_pin_level <= pin;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
      edges_sent++;
   endtask

   task automatic frame_edge(inout int n, input int cut, input int t, input logic pin);
      if (n < cut) begin
         send_edge(t, pin);
      end else if (n == cut) begin
         send_edge($urandom_range(0, MaxTime), 1'($urandom_range(0, 1)));
      end
      n++;
   endtask

   task automatic send_frame(input logic [CodeW-1:0] code, input frame_kind_type kind,
                             input int cut);
      int n;
      int top;
      int lmin;
      int fmin;
      int smax;
      int bmin;
      int split;
      int bmax;
      n = 0;
      top = int'(win.gap_timeout) - 1;
      lmin = int'(win.min_leader_time);
      fmin = int'(win.min_full_leader_space);
      smax = int'(win.max_leader_space);
      bmin = int'(win.min_bit_time);
      split = int'(win.zero_one_split);
      bmax = int'(win.max_bit_time);
      frame_edge(n, cut, pick(int'(win.gap_timeout), MaxTime), 1'($urandom_range(0, 1)));
      frame_edge(n, cut, pick(lmin, lesser(int'(win.max_leader_pulse), top)), 1'b1);
      if (kind == FRAME_REPEAT) begin
         frame_edge(n, cut, pick(lmin, lesser(lesser(fmin - 1, smax), top)), 1'b0);
      end else begin
         frame_edge(n, cut, pick(larger(lmin, fmin), lesser(smax, top)), 1'b0);
         for (int i = 0; i < FrameBits; i++) begin
            frame_edge(n, cut, pick(0, top), 1'b1);
            if (code[i]) begin
               frame_edge(n, cut, pick(larger(split, bmin), lesser(bmax, top)), 1'b0);
            end else begin
               frame_edge(n, cut, pick(bmin, lesser(lesser(split - 1, bmax), top)), 1'b0);
            end
         end
      end
   endtask

   task automatic run_frames(input int count);
      int roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            send_frame(random_code(), FRAME_FULL, NoCut);
         end else if (roll < 72) begin
            send_frame(random_code(), FRAME_REPEAT, NoCut);
         end else if (roll < 90) begin
            send_frame(random_code(), FRAME_FULL, $urandom_range(0, 66));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_edge($urandom_range(0, MaxTime), 1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (code_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (IdleTail) @(negedge clock);
   endtask

   task automatic load_windows(input cfg_type w);
      wait_idle();
      csr_write_enable <= 1'b1;
      for (int i = 0; i < 8; i++) begin
         csr_index <= CsrIndexW'(i);
         case (csr_index_type'(i))
            CSR_MIN_LEADER_TIME:       csr_write_data <= w.min_leader_time;
            CSR_MAX_LEADER_PULSE:      csr_write_data <= w.max_leader_pulse;
            CSR_MIN_FULL_LEADER_SPACE: csr_write_data <= w.min_full_leader_space;
            CSR_MAX_LEADER_SPACE:      csr_write_data <= w.max_leader_space;
            CSR_MIN_BIT_TIME:          csr_write_data <= w.min_bit_time;
            CSR_ZERO_ONE_SPLIT:        csr_write_data <= w.zero_one_split;
            CSR_MAX_BIT_TIME:          csr_write_data <= w.max_bit_time;
            default:                   csr_write_data <= w.gap_timeout;
         endcase
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Window bounds, timeouts from the leader-pulse and data phases, repeat with an empty and with a partial code.
   task automatic test_edge_cases();
      send_edge(0, 1'b1);
      send_edge(MaxTime, 1'b0);
      send_edge(2000, 1'b1);
      send_edge(3999, 1'b0);
      send_edge(100, 1'b0);
      send_edge(9501, 1'b1);
      send_edge(MaxTime, 1'b1);
      send_edge(1999, 1'b0);
      send_edge(MaxTime, 1'b0);
      send_edge(9500, 1'b1);
      send_edge(5001, 1'b0);
      send_edge(MaxTime, 1'b0);
      send_edge(9000, 1'b1);
      send_edge(5000, 1'b0);
      send_edge(9999, 1'b1);
      send_edge(2000, 1'b0);
      send_edge(399, 1'b0);
      send_edge(MaxTime, 1'b0);
      send_edge(9000, 1'b1);
      send_edge(2000, 1'b0);
      send_edge(MaxTime, 1'b0);
      send_edge(9000, 1'b1);
      send_edge(4500, 1'b0);
      send_edge(10000, 1'b1);
   endtask

   task automatic test_nominal_frames();
      send_frame('0, FRAME_FULL, NoCut);
      send_frame('1, FRAME_FULL, NoCut);
      send_frame(32'h00FF_00FF, FRAME_FULL, NoCut);
      run_frames(8);
   endtask

   task automatic test_full_rate();
      idle_pct = 0;
      run_frames(6);
      idle_pct = 25;
   endtask

   task automatic test_back_pressure();
      holds_asked++;
      repeat (4) send_frame(random_code(), FRAME_REPEAT, NoCut);
      send_frame(random_code(), FRAME_FULL, NoCut);
   endtask

   task automatic test_drain_pause();
      send_frame(random_code(), FRAME_FULL, NoCut);
      wait_idle();
      send_frame(random_code(), FRAME_REPEAT, NoCut);
   endtask

   task automatic test_window_sweep();
      load_windows(make_windows(0, MaxTime, 0, MaxTime, 0, 0, MaxTime, MaxTime));
      run_frames(4);
      load_windows(make_windows(0, MaxTime, MaxTime, MaxTime, 0, MaxTime, MaxTime, MaxTime));
      run_frames(4);
      load_windows(make_windows(5000, 5000, 5000, 5000, 800, 800, 800, 9000));
      run_frames(3);
      repeat (3) begin
         load_windows(nominal_windows());
         run_frames(3);
      end
      load_windows(make_windows(2000, 9500, 4000, 5000, 400, 1000, 2000, 1));
      run_frames(2);
      load_windows(make_windows(2000, 9500, 4000, 5000, 400, 1000, 2000, 0));
      run_frames(2);
   endtask

   task automatic test_random_soak();
      int frames;
      frames = 0;
      while (edges_sent < ItemBudget) begin
         if (frames % 10 == 0) begin
            load_windows(($urandom_range(0, 3) == 0) ? ResetWindows : nominal_windows());
         end
         run_frames(1);
         frames++;
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_nominal_frames();
      test_full_rate();
      test_back_pressure();
      test_drain_pause();
      test_window_sweep();
      test_random_soak();
      wait_idle();
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/irpd_pkg.sv
hw/rtl/irpd_csr.sv
hw/rtl/irpd_core.sv
hw/rtl/ir_remote_pulse_distance_decoder.sv
dv/tb_top.sv
